/* hw/rtl/lbbq_pkg.sv */
// Package: payload types and operation/status codes for the linked-block byte queue
`default_nettype none
package lbbq_pkg;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_GET   = 2'd1;
    localparam logic [1:0] OP_UNPUT = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] queue_id;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  result_byte;
        logic [1:0]  status;
        logic [12:0] queue_count;
    } t_out_item;

endpackage
`default_nettype wire

/* hw/rtl/lbbq_ram.sv */
// Generic single-port-write, single-read RAM with registered read data
`default_nettype none
module lbbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/linked_block_byte_queue_manager.sv */
// Top level: linked-block byte queue manager with free list and sequencer
`default_nettype none
// NUM_QUEUES byte FIFOs share NUM_BLOCKS blocks of BLOCK_BYTES bytes, with unused
// blocks chained on a free list. One item is in work at a time; o_ready is low
// from acceptance until its result is taken. After reset a clearing pass over all
// NUM_BLOCKS blocks builds the free-list chain in the link RAM before the
// first item is taken. A put, a get, or an unput inside a block passes through
// decode, one read of the link and byte RAMs, and update before its result is
// shown. An unput that crosses back over a block boundary walks the link chain
// from the head block, one link RAM read per cycle. The byte RAM and the link
// RAM each have one read and one write port.
module linked_block_byte_queue_manager #(
    parameter int NUM_BLOCKS  = 64,
    parameter int BLOCK_BYTES = 64,
    parameter int NUM_QUEUES  = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire lbbq_pkg::t_in_item i_item,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output lbbq_pkg::t_out_item     o_item
);
    localparam int BW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int OW  = $clog2(BLOCK_BYTES);
    localparam int FW  = BW + 1;
    localparam int AW  = BW + OW;
    localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CW  = $clog2(NUM_BLOCKS * BLOCK_BYTES + 1);
    localparam logic [FW-1:0] NO_BLK = FW'(NUM_BLOCKS);
    localparam logic [OW-1:0] OFS_LAST = OW'(BLOCK_BYTES - 1);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_DEC   = 7'b0000100,
        S_RD    = 7'b0001000,
        S_UPD   = 7'b0010000,
        S_WALK  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    lbbq_pkg::t_in_item r_in;
    logic [FW-1:0] r_free;
    logic [BW-1:0] r_hblk [NUM_QUEUES];
    logic [OW-1:0] r_hofs [NUM_QUEUES];
    logic [BW-1:0] r_tblk [NUM_QUEUES];
    logic [OW-1:0] r_tofs [NUM_QUEUES];
    logic [CW-1:0] r_cnt  [NUM_QUEUES];
    logic [BW-1:0] r_init;
    logic [BW-1:0] r_prev;
    logic [BW:0]   r_steps;
    lbbq_pkg::t_out_item r_out;

    // link RAM ports (entries hold FW bits so NUM_BLOCKS marks list end)
    logic          lk_we;
    logic [BW-1:0] lk_waddr, lk_raddr;
    logic [FW-1:0] lk_wdata, lk_rdata;
    // byte RAM ports
    logic          by_we;
    logic [AW-1:0] by_waddr, by_raddr;
    logic [7:0]    by_rdata;

    lbbq_ram #(.WIDTH(FW), .DEPTH(NUM_BLOCKS)) u_link (
        .i_clk(i_clk), .i_we(lk_we), .i_waddr(lk_waddr), .i_wdata(lk_wdata),
        .i_raddr(lk_raddr), .o_rdata(lk_rdata)
    );
    lbbq_ram #(.WIDTH(8), .DEPTH(NUM_BLOCKS * BLOCK_BYTES)) u_bytes (
        .i_clk(i_clk), .i_we(by_we), .i_waddr(by_waddr), .i_wdata(r_in.data_byte),
        .i_raddr(by_raddr), .o_rdata(by_rdata)
    );

    // current queue fields
    logic          q_ok;
    logic [QW-1:0] qi;
    logic [BW-1:0] hb, tb;
    logic [OW-1:0] ho, to;
    logic [CW-1:0] cn;
    logic          free_ok;
    logic [BW-1:0] free_blk;
    assign q_ok     = (32'(r_in.queue_id) < NUM_QUEUES);
    assign qi       = QW'(r_in.queue_id);
    assign hb       = r_hblk[qi];
    assign ho       = r_hofs[qi];
    assign tb       = r_tblk[qi];
    assign to       = r_tofs[qi];
    assign cn       = r_cnt[qi];
    assign free_ok  = (r_free < NO_BLK);
    assign free_blk = r_free[BW-1:0];

    // unput that leaves the tail block empty needs the block before it
    logic walk_need;
    assign walk_need = q_ok && (r_in.operation == lbbq_pkg::OP_UNPUT)
                       && (cn > CW'(1)) && (to == '0);

    // walk decision: link of r_prev read last cycle
    logic walk_go;
    assign walk_go = (lk_rdata[BW-1:0] != tb || lk_rdata[BW]) && (lk_rdata < NO_BLK)
                     && (r_steps < (BW+1)'(NUM_BLOCKS));

    // memory addressing: next free link for put, head link for get, chain for walk
    always_comb begin
        lk_raddr = free_blk;
        by_raddr = {hb, ho};
        if (r_in.operation == lbbq_pkg::OP_UNPUT) begin
            by_raddr = {tb, to};
        end
        if (r_in.operation == lbbq_pkg::OP_GET) begin
            lk_raddr = hb;
        end
        if (r_state == S_UPD && r_in.operation == lbbq_pkg::OP_UNPUT) begin
            lk_raddr = r_prev;
        end
        if (r_state == S_WALK) begin
            // fetch the link of the block the walk moves to
            lk_raddr = lk_rdata[BW-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: if (r_init == BW'(NUM_BLOCKS - 1)) n_state = S_IDLE;
            S_IDLE: if (i_valid) n_state = S_DEC;
            S_DEC:  n_state = S_RD;
            S_RD:   n_state = S_UPD;
            S_UPD:  n_state = walk_need ? S_WALK : S_OUT;
            S_WALK: if (!walk_go) n_state = S_OUT;
            S_OUT:  if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        lk_we <= 1'b0;
        by_we <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_init  <= '0;
            r_free  <= '0;
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_hblk[q] <= '0; r_hofs[q] <= '0;
                r_tblk[q] <= '0; r_tofs[q] <= '0;
                r_cnt[q]  <= '0;
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_INIT: begin
                    // chain block i to i+1
                    lk_we    <= 1'b1;
                    lk_waddr <= r_init;
                    lk_wdata <= FW'(r_init) + FW'(1);
                    r_init   <= r_init + BW'(1);
                end
                S_IDLE: if (i_valid) r_in <= i_item;
                S_DEC: begin
                    r_prev  <= hb;
                    r_steps <= '0;
                end
                S_RD: ;
                S_UPD: begin
                    r_out <= '0;
                    if (!q_ok) begin
                        r_out.status <= lbbq_pkg::ST_EMPTY;
                    end else begin
                        unique case (r_in.operation)
                            lbbq_pkg::OP_PUT: begin
                                r_out.queue_count <= 13'(cn);
                                if (cn == '0 || to == OFS_LAST) begin
                                    if (!free_ok) begin
                                        r_out.status <= lbbq_pkg::ST_FULL;
                                    end else begin
                                        r_free <= lk_rdata;
                                        if (cn != '0) begin
                                            lk_we    <= 1'b1;
                                            lk_waddr <= tb;
                                            lk_wdata <= {1'b0, free_blk};
                                        end else begin
                                            r_hblk[qi] <= free_blk;
                                            r_hofs[qi] <= '0;
                                        end
                                        r_tblk[qi] <= free_blk;
                                        r_tofs[qi] <= '0;
                                        r_cnt[qi]  <= cn + CW'(1);
                                        r_out.queue_count <= 13'(cn + CW'(1));
                                        by_we    <= 1'b1;
                                        by_waddr <= {free_blk, {OW{1'b0}}};
                                    end
                                end else begin
                                    r_tofs[qi] <= to + OW'(1);
                                    r_cnt[qi]  <= cn + CW'(1);
                                    r_out.queue_count <= 13'(cn + CW'(1));
                                    by_we    <= 1'b1;
                                    by_waddr <= {tb, to + OW'(1)};
                                end
                            end
                            lbbq_pkg::OP_GET: begin
                                if (cn == '0) begin
                                    r_out.status <= lbbq_pkg::ST_EMPTY;
                                end else begin
                                    r_out.result_byte <= by_rdata;
                                    r_cnt[qi] <= cn - CW'(1);
                                    r_out.queue_count <= 13'(cn - CW'(1));
                                    if (cn == CW'(1) || ho == OFS_LAST) begin
                                        lk_we    <= 1'b1;
                                        lk_waddr <= hb;
                                        lk_wdata <= r_free;
                                        r_free   <= {1'b0, hb};
                                    end
                                    if (cn == CW'(1)) begin
                                        r_hblk[qi] <= '0; r_hofs[qi] <= '0;
                                        r_tblk[qi] <= '0; r_tofs[qi] <= '0;
                                    end else if (ho == OFS_LAST) begin
                                        // lk_rdata holds link of head block
                                        r_hblk[qi] <= lk_rdata[BW-1:0];
                                        r_hofs[qi] <= '0;
                                    end else begin
                                        r_hofs[qi] <= ho + OW'(1);
                                    end
                                end
                            end
                            lbbq_pkg::OP_UNPUT: begin
                                if (cn == '0) begin
                                    r_out.status <= lbbq_pkg::ST_EMPTY;
                                end else begin
                                    r_out.result_byte <= by_rdata;
                                    r_cnt[qi] <= cn - CW'(1);
                                    r_out.queue_count <= 13'(cn - CW'(1));
                                    if (cn == CW'(1)) begin
                                        lk_we    <= 1'b1;
                                        lk_waddr <= tb;
                                        lk_wdata <= r_free;
                                        r_free   <= {1'b0, tb};
                                        r_hblk[qi] <= '0; r_hofs[qi] <= '0;
                                        r_tblk[qi] <= '0; r_tofs[qi] <= '0;
                                    end else if (to == '0) begin
                                        // tail moves once the walk finds the block before it
                                    end else begin
                                        r_tofs[qi] <= to - OW'(1);
                                    end
                                end
                            end
                            default: r_out.queue_count <= 13'(cn);
                        endcase
                    end
                end
                S_WALK: begin
                    // one link per cycle: follow chain until it points at tail block, list end or step limit
                    if (walk_go) begin
                        r_prev  <= lk_rdata[BW-1:0];
                        r_steps <= r_steps + (BW+1)'(1);
                    end else begin
                        lk_we    <= 1'b1;
                        lk_waddr <= tb;
                        lk_wdata <= r_free;
                        r_free   <= {1'b0, tb};
                        r_tblk[qi] <= r_prev;
                        r_tofs[qi] <= OFS_LAST;
                    end
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    // output and input handshakes never both open
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid both high");
    // result stays until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_item)))
        else $error("result dropped");
    // free head never beyond the end marker
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= NO_BLK) else $error("free head out of range");
`endif
endmodule
`default_nettype wire
